FILE: rtl/qang_pkg.sv
// qang_pkg: shared constants, types and the sine/cosine degree tables
`default_nettype none

package qang_pkg;

	// sample width of the levels, samples and zero level
	localparam int SAMPLE_BITS = 12;

	// base angle 0..89 needs seven bits, one search step per bit
	localparam int A_BITS    = 7;
	localparam int MAX_ANGLE = 89;
	localparam int ROM_DEPTH = 1 << A_BITS;

	// table entries: unsigned Q46, one extra bit so cos(0) = 1.0 fits
	localparam int ROM_FRAC = 46;
	localparam int ROM_W    = ROM_FRAC + 1;
	localparam int PROD_W   = SAMPLE_BITS + ROM_W;

	localparam int IN_FIELDS_W  = 4 * SAMPLE_BITS;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int ANGLE_W      = 9;
	localparam int QUAD_W       = 2;
	localparam int OUT_FIELDS_W = ANGLE_W + QUAD_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [SAMPLE_BITS-1:0] ZERO_RESET = SAMPLE_BITS'(2048);

	localparam logic [ANGLE_W-1:0] DEG_HALF = ANGLE_W'(180);
	localparam logic [ANGLE_W-1:0] DEG_FULL = ANGLE_W'(360);

	typedef enum logic [QUAD_W-1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	// one item as it moves through the search steps
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sl;
		logic [SAMPLE_BITS-1:0] cl;
		logic [A_BITS-1:0]      a;
		logic [A_BITS-1:0]      probe;
		quad_t                  quad;
	} work_t;

	typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] rom_t;

	localparam logic [63:0]  ONE_Q62 = 64'h4000_0000_0000_0000;
	localparam logic [63:0]  PI_Q60  = 64'h3243_F6A8_885A_308D;

	// floor(a * b / 2^62)
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// degree tables: one-degree rotation recurrence in Q62, truncated to Q46
	function automatic rom_t trig_tab(input logic want_cos);
		logic [63:0] x, x2, x3, x4, x5, x6, x7, x8, x9;
		logic [63:0] s1, c1, s, c, ns, nc;
		rom_t st, ct;
		st = '0;
		ct = '0;
		x  = PI_Q60 / 64'd45;
		x2 = mul_q62(x, x);
		x3 = mul_q62(x2, x);
		x4 = mul_q62(x2, x2);
		x5 = mul_q62(x4, x);
		x6 = mul_q62(x4, x2);
		x7 = mul_q62(x6, x);
		x8 = mul_q62(x4, x4);
		x9 = mul_q62(x8, x);
		s1 = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040 + x9 / 64'd362880;
		c1 = ONE_Q62 - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
		s  = 64'd0;
		c  = ONE_Q62;
		for (int k = 0; k <= 45; k++) begin
			st[k] = ROM_W'(s >> 16);
			ct[k] = ROM_W'(c >> 16);
			ns = mul_q62(s, c1) + mul_q62(c, s1);
			nc = mul_q62(c, c1) - mul_q62(s, s1);
			s  = ns;
			c  = nc;
		end
		// equal entries at 45 so a unit ratio lands on 45
		ct[45] = st[45];
		for (int k = 46; k <= 90; k++) begin
			st[k] = ct[90 - k];
			ct[k] = st[90 - k];
		end
		return want_cos ? ct : st;
	endfunction

	localparam rom_t SIN_TAB = trig_tab(1'b0);
	localparam rom_t COS_TAB = trig_tab(1'b1);

endpackage

`default_nettype wire

FILE: rtl/sin_cos_quadrant_angle_top.sv
// sin_cos_quadrant_angle_top: angle in whole degrees of a sine/cosine pair
//
// channel   dir  signals                 contents
// s_axis    in   tvalid tready tdata[48] sin_level, cos_level, sin_sample, cos_sample
// m_axis    out  tvalid tready tdata[16] angle_deg, quadrant
// cfg       in   cfg_wr_en cfg_wr_data   zero_level
//
// one transaction per cycle sustained while m_axis_tready stays high; stages:
// an input stage, seven search steps of two stages each (table read, then two
// 12x47 multiplies and a compare), and the output register
// reset clears all valid bits and loads zero_level with 2048
// every stage holds its item on a stall and takes a new one as soon as it frees
`default_nettype none

module sin_cos_quadrant_angle_top (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// sin_level, cos_level, sin_sample, cos_sample from bit 0
	input  wire  [qang_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// angle_deg, quadrant from bit 0, zero fill above
	output logic [qang_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire                                  cfg_wr_en,
	input  wire  [qang_pkg::SAMPLE_BITS-1:0]     cfg_wr_data
);

	localparam int SB = qang_pkg::SAMPLE_BITS;

	logic [SB-1:0]          zero_level_q;

	logic [SB-1:0]          sin_level;
	logic [SB-1:0]          cos_level;
	logic [SB-1:0]          sin_sample;
	logic [SB-1:0]          cos_sample;
	logic                   spos;
	logic                   cpos;
	qang_pkg::quad_t        quad;

	logic                   v0_q;
	logic                   ready0;
	qang_pkg::work_t        work_s0;

	logic                   step_valid [qang_pkg::A_BITS+1];
	logic                   step_ready [qang_pkg::A_BITS+1];
	qang_pkg::work_t        step_work  [qang_pkg::A_BITS+1];

	logic                   out_ready;
	qang_pkg::work_t        fin;
	logic [qang_pkg::ANGLE_W-1:0] a_ext;
	logic [qang_pkg::ANGLE_W-1:0] angle;
	logic [qang_pkg::ANGLE_W-1:0] angle_q;
	qang_pkg::quad_t        quad_q;

	// zero level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_level_q <= qang_pkg::ZERO_RESET;
		end else if (cfg_wr_en) begin
			zero_level_q <= cfg_wr_data;
		end
	end

	// unpack input fields
	assign sin_level  = s_axis_tdata[SB-1:0];
	assign cos_level  = s_axis_tdata[2*SB-1:SB];
	assign sin_sample = s_axis_tdata[3*SB-1:2*SB];
	assign cos_sample = s_axis_tdata[4*SB-1:3*SB];

	// quadrant from the sample signs
	assign spos = sin_sample >= zero_level_q;
	assign cpos = cos_sample >= zero_level_q;

	always_comb begin
		case ({spos, cpos})
			2'b11:   quad = qang_pkg::QUAD_I;
			2'b10:   quad = qang_pkg::QUAD_II;
			2'b00:   quad = qang_pkg::QUAD_III;
			2'b01:   quad = qang_pkg::QUAD_IV;
			default: quad = qang_pkg::QUAD_I;
		endcase
	end

	// input stage
	assign ready0        = !v0_q || step_ready[0];
	assign s_axis_tready = ready0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
		end else if (ready0) begin
			v0_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready0 && s_axis_tvalid) begin
			work_s0.sl    <= sin_level;
			// zero cosine level counts as one
			work_s0.cl    <= (cos_level == '0) ? SB'(1) : cos_level;
			work_s0.a     <= '0;
			work_s0.probe <= qang_pkg::A_BITS'(1) << (qang_pkg::A_BITS - 1);
			work_s0.quad  <= quad;
		end
	end

	assign step_valid[0] = v0_q;
	assign step_work[0]  = work_s0;

	// binary search, most significant bit first
	for (genvar i = 0; i < qang_pkg::A_BITS; i++) begin : g_step
		qang_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (step_valid[i]),
			.in_ready  (step_ready[i]),
			.in_work   (step_work[i]),
			.out_valid (step_valid[i+1]),
			.out_ready (step_ready[i+1]),
			.out_work  (step_work[i+1])
		);
	end

	// quadrant correction
	assign fin   = step_work[qang_pkg::A_BITS];
	assign a_ext = qang_pkg::ANGLE_W'(fin.a);

	always_comb begin
		case (fin.quad)
			qang_pkg::QUAD_I:   angle = a_ext;
			qang_pkg::QUAD_II:  angle = qang_pkg::DEG_HALF - a_ext;
			qang_pkg::QUAD_III: angle = qang_pkg::DEG_HALF + a_ext;
			qang_pkg::QUAD_IV:  angle = qang_pkg::DEG_FULL - a_ext;
			default:            angle = a_ext;
		endcase
	end

	// output register
	assign out_ready                    = !m_axis_tvalid || m_axis_tready;
	assign step_ready[qang_pkg::A_BITS] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_ready) begin
			m_axis_tvalid <= step_valid[qang_pkg::A_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && step_valid[qang_pkg::A_BITS]) begin
			angle_q <= angle;
			quad_q  <= fin.quad;
		end
	end

	assign m_axis_tdata = qang_pkg::OUT_DATA_W'({quad_q, angle_q});

endmodule

`default_nettype wire

FILE: rtl/qang_step.sv
// qang_step: one bit of the base angle search, table read then cross-multiply compare
`default_nettype none

module qang_step (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  qang_pkg::work_t      in_work,
	output logic                 out_valid,
	input  wire                  out_ready,
	output qang_pkg::work_t      out_work
);

	logic                             v1_q;
	logic                             ready1;
	qang_pkg::work_t                  work_s1;
	logic [qang_pkg::A_BITS-1:0]      cand_s1;
	logic                             in_range_s1;
	logic [qang_pkg::ROM_W-1:0]       sin_s1;
	logic [qang_pkg::ROM_W-1:0]       cos_s1;
	logic [qang_pkg::A_BITS-1:0]      cand;

	logic                             v2_q;
	logic                             ready2;
	qang_pkg::work_t                  work_s2;
	qang_pkg::work_t                  next_work;
	logic [qang_pkg::PROD_W-1:0]      lhs;
	logic [qang_pkg::PROD_W-1:0]      rhs;
	logic                             hit;

	// ready chain, bubbles are filled
	assign ready2   = !v2_q || out_ready;
	assign ready1   = !v1_q || ready2;
	assign in_ready = ready1;

	// candidate angle for this bit
	assign cand = in_work.a | in_work.probe;

	// stage 1: table lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (ready1) begin
			v1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1 && in_valid) begin
			work_s1     <= in_work;
			cand_s1     <= cand;
			in_range_s1 <= (cand <= qang_pkg::A_BITS'(qang_pkg::MAX_ANGLE));
			sin_s1      <= qang_pkg::SIN_TAB[cand];
			cos_s1      <= qang_pkg::COS_TAB[cand];
		end
	end

	// stage 2: sl * cos(k) >= cl * sin(k) keeps the bit, if k is at most 89
	assign lhs = qang_pkg::PROD_W'(work_s1.sl) * qang_pkg::PROD_W'(cos_s1);
	assign rhs = qang_pkg::PROD_W'(work_s1.cl) * qang_pkg::PROD_W'(sin_s1);
	assign hit = in_range_s1 && (lhs >= rhs);

	// item after this bit is decided
	always_comb begin
		next_work       = work_s1;
		next_work.a     = hit ? cand_s1 : work_s1.a;
		next_work.probe = work_s1.probe >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (ready2) begin
			v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ready2 && v1_q) begin
			work_s2 <= next_work;
		end
	end

	assign out_valid = v2_q;
	assign out_work  = work_s2;

endmodule

`default_nettype wire

FILE: dv/angle_checker.sv
// angle checker: predicts angle and quadrant per input transaction and compares results
`timescale 1ns / 1ps

module angle_checker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	input  wire                               s_axis_tready,
	input  wire  [qang_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  wire                               m_axis_tvalid,
	input  wire                               m_axis_tready,
	input  wire  [qang_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  wire                               cfg_wr_en,
	input  wire  [qang_pkg::SAMPLE_BITS-1:0]  cfg_wr_data,
	output int                                fail_count,
	output int                                pending_count
);

	localparam int SB = qang_pkg::SAMPLE_BITS;
	localparam int AW = qang_pkg::ANGLE_W;
	localparam int FW = qang_pkg::OUT_FIELDS_W;
	localparam int DW = qang_pkg::OUT_DATA_W;

	localparam bit [63:0] UNIT_Q62   = 64'h4000_0000_0000_0000;
	localparam bit [63:0] HALF_TURN  = 64'h3243_F6A8_885A_308D;

	typedef struct {
		logic [AW-1:0]   angle;
		qang_pkg::quad_t quad;
	} angle_res_t;

	angle_res_t             expected_angles[$];
	logic [SB-1:0]          zero_copy;
	bit [63:0]              deg_sin[0:90];
	bit [63:0]              deg_cos[0:90];

	// floor(a * b / 2^62)
	function automatic bit [63:0] q62_product(bit [63:0] a, bit [63:0] b);
		bit [127:0] wide;
		wide = 128'(a) * 128'(b);
		return wide[125:62];
	endfunction

	// whole-degree sine and cosine tables in Q46
	initial begin
		bit [63:0] rad, p2, p3, p4, p5, p6, p7, p8, p9;
		bit [63:0] step_s, step_c, cur_s, cur_c, nxt_s, nxt_c;
		rad = HALF_TURN / 64'd45;
		p2 = q62_product(rad, rad);
		p3 = q62_product(p2, rad);
		p4 = q62_product(p2, p2);
		p5 = q62_product(p4, rad);
		p6 = q62_product(p4, p2);
		p7 = q62_product(p6, rad);
		p8 = q62_product(p4, p4);
		p9 = q62_product(p8, rad);
		step_s = rad - p3 / 64'd6 + p5 / 64'd120 - p7 / 64'd5040 + p9 / 64'd362880;
		step_c = UNIT_Q62 - p2 / 64'd2 + p4 / 64'd24 - p6 / 64'd720 + p8 / 64'd40320;
		cur_s = 64'd0;
		cur_c = UNIT_Q62;
		for (int k = 0; k <= 45; k++) begin
			deg_sin[k] = cur_s >> 16;
			deg_cos[k] = cur_c >> 16;
			nxt_s = q62_product(cur_s, step_c) + q62_product(cur_c, step_s);
			nxt_c = q62_product(cur_c, step_c) - q62_product(cur_s, step_s);
			cur_s = nxt_s;
			cur_c = nxt_c;
		end
		// unit ratio must land exactly on 45
		deg_cos[45] = deg_sin[45];
		for (int k = 46; k <= 90; k++) begin
			deg_sin[k] = deg_cos[90 - k];
			deg_cos[k] = deg_sin[90 - k];
		end
	end

	// base angle by table compare, then quadrant fold
	function automatic angle_res_t predict_angle(logic [qang_pkg::IN_DATA_W-1:0] item,
		logic [SB-1:0] zero);
		bit [63:0]              num, den;
		logic [AW-1:0]          base;
		logic [SB-1:0]          sin_raw, cos_raw;
		bit                     sin_pos, cos_pos;
		angle_res_t             res;
		num     = 64'(item[SB-1:0]);
		den     = 64'(item[2*SB-1:SB]);
		sin_raw = item[3*SB-1:2*SB];
		cos_raw = item[4*SB-1:3*SB];
		if (den == 0) begin
			den = 64'd1;
		end
		base = '0;
		for (int k = 1; k <= 89; k++) begin
			if (num * deg_cos[k] >= den * deg_sin[k]) begin
				base++;
			end
		end
		sin_pos = sin_raw >= zero;
		cos_pos = cos_raw >= zero;
		if (sin_pos && cos_pos) begin
			res.quad  = qang_pkg::QUAD_I;
			res.angle = base;
		end else if (sin_pos) begin
			res.quad  = qang_pkg::QUAD_II;
			res.angle = AW'(180) - base;
		end else if (!cos_pos) begin
			res.quad  = qang_pkg::QUAD_III;
			res.angle = AW'(180) + base;
		end else begin
			res.quad  = qang_pkg::QUAD_IV;
			res.angle = AW'(360) - base;
		end
		return res;
	endfunction

	// result compare first, then new prediction, then register write
	always @(posedge clk or negedge arst_n) begin
		angle_res_t want;
		if (!arst_n) begin
			zero_copy = qang_pkg::ZERO_RESET;
			expected_angles.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_angles.size() == 0) begin
					$error("angle_deg: unexpected transaction, expected none, actual %0d",
						m_axis_tdata[AW-1:0]);
					fail_count++;
				end else begin
					want = expected_angles.pop_front();
					if (m_axis_tdata[AW-1:0] !== want.angle) begin
						$error("angle_deg mismatch: expected %0d, actual %0d",
							want.angle, m_axis_tdata[AW-1:0]);
						fail_count++;
					end
					if (m_axis_tdata[FW-1:AW] !== want.quad) begin
						$error("quadrant mismatch: expected %0d, actual %0d",
							want.quad, m_axis_tdata[FW-1:AW]);
						fail_count++;
					end
					if (m_axis_tdata[DW-1:FW] !== '0) begin
						$error("zero fill mismatch: expected 0, actual %0h",
							m_axis_tdata[DW-1:FW]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_angles.push_back(predict_angle(s_axis_tdata, zero_copy));
			end
			if (cfg_wr_en) begin
				zero_copy = cfg_wr_data;
			end
			pending_count = expected_angles.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
// testbench top: clock, reset, stimulus phases with idling and the final verdict
`timescale 1ns / 1ps

module tb_top;

	localparam int SB        = qang_pkg::SAMPLE_BITS;
	localparam int LEVEL_MAX = (1 << SB) - 1;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [qang_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [qang_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                            cfg_wr_en = 1'b0;
	logic [SB-1:0]                   cfg_wr_data = '0;
	int                              fail_count;
	int                              pending_count;
	// idle and stall chances in percent
	int                              src_idle_pct = 0;
	int                              rx_stall_pct = 0;

	sin_cos_quadrant_angle_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	angle_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #2 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// result side backpressure
	always @(negedge clk) begin
		m_axis_tready <= (int'($urandom_range(0, 99)) >= rx_stall_pct);
	end

	function automatic int clamp_level(int v);
		if (v < 0) begin
			return 0;
		end
		if (v > LEVEL_MAX) begin
			return LEVEL_MAX;
		end
		return v;
	endfunction

	// raw sample: uniform or hugging the zero level
	function automatic logic [SB-1:0] pick_sample(int zero);
		if ($urandom_range(0, 1) == 0) begin
			return SB'($urandom_range(0, LEVEL_MAX));
		end
		return SB'(clamp_level(zero + int'($urandom_range(0, 4)) - 2));
	endfunction

	// one input transaction, held until accepted
	task automatic send_pair(input int sl, input int cl, input int ss, input int cs);
		while (int'($urandom_range(0, 99)) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {SB'(cs), SB'(ss), SB'(cl), SB'(sl)};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// random levels: uniform, small, near a degree boundary, near unity, zeros
	task automatic send_random(input int zero);
		int  sl, cl, kind, k, big, nudge;
		real slope;
		kind  = $urandom_range(0, 9);
		nudge = int'($urandom_range(0, 2)) - 1;
		if (kind <= 3) begin
			sl = $urandom_range(0, LEVEL_MAX);
			cl = $urandom_range(0, LEVEL_MAX);
		end else if (kind <= 5) begin
			sl = $urandom_range(0, 63);
			cl = $urandom_range(0, 63);
		end else if (kind <= 7) begin
			k     = $urandom_range(1, 89);
			big   = $urandom_range(1, LEVEL_MAX);
			slope = $tan(real'(k) * 3.141592653589793 / 180.0);
			if (slope <= 1.0) begin
				cl = big;
				sl = clamp_level($rtoi(real'(big) * slope) + nudge);
			end else begin
				sl = big;
				cl = clamp_level($rtoi(real'(big) / slope) + nudge);
			end
		end else if (kind == 8) begin
			sl = $urandom_range(0, LEVEL_MAX);
			cl = clamp_level(sl + nudge);
		end else begin
			sl = $urandom_range(0, LEVEL_MAX);
			cl = 0;
			if ($urandom_range(0, 1) == 1) begin
				cl = sl;
				sl = 0;
			end
		end
		send_pair(sl, cl, pick_sample(zero), pick_sample(zero));
	endtask

	// stop sending and let every transaction come back
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_zero_level(input int zero);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= SB'(zero);
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// stimulus
	initial begin
		int zero;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset zero level of 2048
		send_pair(0, 0, 4095, 4095);          // zero sine level, zero cosine level
		send_pair(4095, 0, 4095, 4095);       // zero cosine level saturates at 89
		send_pair(57, 0, 2048, 2048);         // just under the saturation point
		send_pair(58, 0, 2048, 2048);
		send_pair(1, 0, 2048, 2048);
		send_pair(100, 100, 2048, 2047);      // unit ratio, second quadrant
		send_pair(4095, 4095, 0, 0);          // unit ratio, third quadrant
		send_pair(0, 4095, 2047, 2048);       // fourth quadrant with zero angle gives 360
		send_pair(0, 0, 0, 4095);
		send_pair(4095, 1, 4095, 0);
		send_pair(1, 4095, 0, 0);
		send_pair(0, 5, 2048, 0);
		send_pair(4095, 0, 2047, 2047);
		send_pair(4095, 0, 2047, 2048);
		send_pair(1, 57, 2048, 2048);         // tiny ratios around one degree
		send_pair(1, 58, 2048, 2048);
		send_pair(2047, 2048, 2048, 2048);    // either side of 45
		send_pair(2048, 2047, 2048, 2048);
		send_pair(4095, 4094, 2047, 2048);
		send_pair(4094, 4095, 2048, 2047);
		send_pair(3000, 1000, 2049, 2046);
		send_pair(1000, 3000, 2046, 2049);

		// random phases, each with its own zero level and idling mode
		for (int phase = 0; phase < 8; phase++) begin
			drain();
			case (phase)
				0: zero = 0;
				1: zero = LEVEL_MAX;
				3: zero = 2048;
				5: zero = 1;
				6: zero = LEVEL_MAX - 1;
				default: zero = $urandom_range(0, LEVEL_MAX);
			endcase
			// no idling, sender idle, receiver stalling, both lightly
			case (phase % 4)
				0: begin
					src_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 88;
					rx_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					rx_stall_pct = 88;
				end
				default: begin
					src_idle_pct = 22;
					rx_stall_pct = 22;
				end
			endcase
			write_zero_level(zero);
			for (int n = 0; n < 175; n++) begin
				send_random(zero);
			end
		end

		drain();
		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/qang_pkg.sv
rtl/qang_step.sv
rtl/sin_cos_quadrant_angle_top.sv
dv/angle_checker.sv
dv/tb_top.sv
